FILE: rtl/core/ssag_pkg.sv
// Shared types and constants for the strided slice address generator.
// Holds function codes, register indexes, field widths and the controller/datapath bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssag_pkg;

  localparam int MAX_RANK = 8;
  localparam int DIM_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RANK_W   = $clog2(MAX_RANK + 1);

  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int EXT_W    = 32;
  localparam int OFF_W    = 48;
  localparam int IDX_W    = 40;
  localparam int CSZ_W    = 32;
  localparam int ARANK_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 48;

  // multiplier: 32-bit operand times 24-bit slice
  localparam int MUL_A_W  = 32;
  localparam int MUL_B_W  = 24;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  localparam int DIV_CNT_W = $clog2(IDX_W);

  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEEK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EMIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_RANK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE  = 2'd2;

  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_CHUNK = 1'b1;

  typedef logic [DIM_W-1:0] dim_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_take;
    logic mul_lo;
    logic mul_hi;
    logic mul_fin;
    logic step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic dim_zero;
    logic step_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/ssag_div.sv
// Bit-serial restoring divider: 40-bit dividend by 33-bit divisor, one quotient bit per cycle.
// Depends on ssag_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module ssag_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [ssag_pkg::IDX_W-1:0]   dividend,
  input  wire logic [ssag_pkg::EXT_W:0]     divisor,
  output logic                              done,
  output logic [ssag_pkg::IDX_W-1:0]        quotient,
  output logic [ssag_pkg::EXT_W-1:0]        remainder
);

  logic                             busy;
  logic [ssag_pkg::DIV_CNT_W-1:0]   cnt;
  logic [ssag_pkg::IDX_W-1:0]       q;
  logic [ssag_pkg::EXT_W:0]         r;
  logic [ssag_pkg::EXT_W:0]         d;
  logic [ssag_pkg::EXT_W+1:0]       r_sh;
  logic [ssag_pkg::EXT_W+1:0]       r_sub;
  logic                             fits;

  assign r_sh  = {r, q[ssag_pkg::IDX_W-1]};
  assign r_sub = r_sh - {1'b0, d};
  assign fits  = r_sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == ssag_pkg::DIV_CNT_W'(ssag_pkg::IDX_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      q <= {q[ssag_pkg::IDX_W-2:0], fits};
      r <= fits ? r_sub[ssag_pkg::EXT_W:0] : r_sh[ssag_pkg::EXT_W:0];
    end
  end

  assign quotient  = q;
  assign remainder = r[ssag_pkg::EXT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/ssag_datapath.sv
// Datapath: configuration registers, dimension tables, coordinates, offsets, shared multiplier,
// divider and result register. Depends on ssag_pkg and ssag_div.
`timescale 1ns / 1ps
`default_nettype none

module ssag_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ssag_pkg::ctrl_cmd_t               cmd,
  output ssag_pkg::ctrl_sts_t                    sts,
  input  wire logic                              cfg_we,
  input  wire logic [ssag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssag_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic [ssag_pkg::FUNC_W-1:0]       func,
  input  wire logic [ssag_pkg::SLOT_W-1:0]       dim_slot,
  input  wire logic [ssag_pkg::EXT_W-1:0]        extent,
  input  wire logic signed [ssag_pkg::OFF_W-1:0] step_bytes,
  input  wire logic signed [ssag_pkg::OFF_W-1:0] rewind_bytes,
  input  wire logic [ssag_pkg::IDX_W-1:0]        chunk_index,
  input  wire logic                              rsp_stall,
  output logic                                   rsp_valid,
  output logic                                   kind,
  output logic [ssag_pkg::OFF_W-1:0]             src_offset,
  output logic [ssag_pkg::OFF_W-1:0]             dest_offset,
  output logic [ssag_pkg::CSZ_W-1:0]             byte_count,
  output logic                                   wrapped
);

  function automatic logic [ssag_pkg::EXT_W:0] eff_extent(input logic [ssag_pkg::EXT_W-1:0] e);
    eff_extent = (e == '0) ? {1'b1, {ssag_pkg::EXT_W{1'b0}}} : {1'b0, e};
  endfunction

  // configuration
  logic [ssag_pkg::ARANK_W-1:0] active_rank;
  logic [ssag_pkg::OFF_W-1:0]   base_offset;
  logic [ssag_pkg::CSZ_W-1:0]   chunk_size;

  // tables and walk state
  logic [ssag_pkg::EXT_W-1:0] extent_tab [ssag_pkg::MAX_RANK];
  logic [ssag_pkg::OFF_W-1:0] stride_tab [ssag_pkg::MAX_RANK];
  logic [ssag_pkg::OFF_W-1:0] rewind_tab [ssag_pkg::MAX_RANK];
  logic [ssag_pkg::EXT_W-1:0] coord      [ssag_pkg::MAX_RANK];
  logic [ssag_pkg::OFF_W-1:0] cur_offset;
  logic [ssag_pkg::IDX_W-1:0] cur_chunk;

  // per-item working registers
  ssag_pkg::dim_t              dim;
  logic [ssag_pkg::IDX_W-1:0]  quot;
  logic [ssag_pkg::OFF_W-1:0]  acc;
  logic [ssag_pkg::PROD_W-1:0] prod;
  logic [ssag_pkg::OFF_W-1:0]  src_hold;
  logic                        wrapped_r;
  logic                        kind_r;
  logic                        emit_r;

  logic [ssag_pkg::RANK_W-1:0]  rank_eff;
  ssag_pkg::dim_t               dim_start;
  logic                         slot_ok;
  logic [ssag_pkg::MUL_A_W-1:0] mul_a;
  logic [ssag_pkg::MUL_B_W-1:0] mul_b;
  logic [ssag_pkg::PROD_W-1:0]  mul_p;
  logic [ssag_pkg::OFF_W-1:0]   acc_next;
  logic [ssag_pkg::EXT_W:0]     ext_d;
  logic [ssag_pkg::EXT_W:0]     coord_inc;
  logic                         fits;
  logic                         dim_zero;
  logic                         div_done;
  logic [ssag_pkg::IDX_W-1:0]   div_quot;
  logic [ssag_pkg::EXT_W-1:0]   div_rem;

  always_comb begin
    if (active_rank == '0) begin
      rank_eff = ssag_pkg::RANK_W'(1);
    end else if (32'(active_rank) > 32'(ssag_pkg::MAX_RANK)) begin
      rank_eff = ssag_pkg::RANK_W'(ssag_pkg::MAX_RANK);
    end else begin
      rank_eff = ssag_pkg::RANK_W'(active_rank);
    end
  end

  assign dim_start = ssag_pkg::dim_t'(rank_eff - 1'b1);
  assign slot_ok   = 32'(dim_slot) < 32'(ssag_pkg::MAX_RANK);
  assign dim_zero  = dim == '0;

  // operand select: emit forms chunk * chunk_size, seek forms coordinate * stride
  always_comb begin
    if (emit_r) begin
      mul_a = chunk_size;
      mul_b = cmd.mul_hi ? ssag_pkg::MUL_B_W'(cur_chunk[ssag_pkg::IDX_W-1:ssag_pkg::MUL_B_W])
                         : cur_chunk[ssag_pkg::MUL_B_W-1:0];
    end else begin
      mul_a = coord[dim];
      mul_b = cmd.mul_hi ? stride_tab[dim][ssag_pkg::OFF_W-1:ssag_pkg::MUL_B_W]
                         : stride_tab[dim][ssag_pkg::MUL_B_W-1:0];
    end
  end

  assign mul_p    = {{ssag_pkg::MUL_B_W{1'b0}}, mul_a} * {{ssag_pkg::MUL_A_W{1'b0}}, mul_b};
  assign acc_next = acc + {prod[ssag_pkg::OFF_W-ssag_pkg::MUL_B_W-1:0],
                           {ssag_pkg::MUL_B_W{1'b0}}};

  assign ext_d     = eff_extent(extent_tab[dim]);
  assign coord_inc = {1'b0, coord[dim]} + 1'b1;
  assign fits      = coord_inc < ext_d;

  ssag_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (quot),
    .divisor   (ext_d),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign sts.div_done  = div_done;
  assign sts.dim_zero  = dim_zero;
  assign sts.step_last = fits || dim_zero;
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  // state with defined reset
  always_ff @(posedge clk) begin
    if (rst) begin
      active_rank <= ssag_pkg::ARANK_W'(1);
      base_offset <= '0;
      chunk_size  <= ssag_pkg::CSZ_W'(1);
      cur_offset  <= '0;
      cur_chunk   <= '0;
      rsp_valid   <= 1'b0;
      for (int i = 0; i < ssag_pkg::MAX_RANK; i++) begin
        coord[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ssag_pkg::REG_ACTIVE_RANK: active_rank <= cfg_data[ssag_pkg::ARANK_W-1:0];
          ssag_pkg::REG_BASE_OFFSET: base_offset <= cfg_data[ssag_pkg::OFF_W-1:0];
          ssag_pkg::REG_CHUNK_SIZE:  chunk_size  <= cfg_data[ssag_pkg::CSZ_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept && func == ssag_pkg::FUNC_SEEK) begin
        cur_chunk <= chunk_index;
      end
      if (cmd.div_take) begin
        coord[dim] <= div_rem;
      end
      if (cmd.mul_fin && !emit_r && dim_zero) begin
        cur_offset <= acc_next;
      end
      if (cmd.step) begin
        if (fits) begin
          coord[dim] <= coord_inc[ssag_pkg::EXT_W-1:0];
          cur_offset <= cur_offset + stride_tab[dim];
        end else begin
          coord[dim] <= '0;
          cur_offset <= cur_offset - rewind_tab[dim];
        end
        if (fits || dim_zero) begin
          cur_chunk <= cur_chunk + 1'b1;
        end
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // tables and per-item payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r    <= (func == ssag_pkg::FUNC_EMIT) ? ssag_pkg::KIND_CHUNK : ssag_pkg::KIND_ACK;
      emit_r    <= func == ssag_pkg::FUNC_EMIT;
      wrapped_r <= 1'b0;
      dim       <= dim_start;
      src_hold  <= cur_offset;
      quot      <= chunk_index;
      acc       <= (func == ssag_pkg::FUNC_SEEK) ? base_offset : '0;
      if (func == ssag_pkg::FUNC_LOAD && slot_ok) begin
        extent_tab[ssag_pkg::dim_t'(dim_slot)] <= extent;
        stride_tab[ssag_pkg::dim_t'(dim_slot)] <= step_bytes;
        rewind_tab[ssag_pkg::dim_t'(dim_slot)] <= rewind_bytes;
      end
    end
    if (cmd.div_take) begin
      quot <= div_quot;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      prod <= mul_p;
    end
    if (cmd.mul_hi) begin
      acc <= acc + prod[ssag_pkg::OFF_W-1:0];
    end
    if (cmd.mul_fin) begin
      acc <= acc_next;
      if (!emit_r && !dim_zero) begin
        dim <= dim - 1'b1;
      end
    end
    if (cmd.step && !fits) begin
      if (dim_zero) begin
        wrapped_r <= 1'b1;
      end else begin
        dim <= dim - 1'b1;
      end
    end
    if (cmd.out_load) begin
      kind <= kind_r;
      if (kind_r == ssag_pkg::KIND_CHUNK) begin
        src_offset  <= src_hold;
        dest_offset <= acc;
        byte_count  <= chunk_size;
        wrapped     <= wrapped_r;
      end else begin
        src_offset  <= '0;
        dest_offset <= '0;
        byte_count  <= '0;
        wrapped     <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ssag_ctrl.sv
// Controller state machine: sequences load, seek and emit items through the datapath.
// Depends on ssag_pkg for the command and status bundles.
`timescale 1ns / 1ps
`default_nettype none

module ssag_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  input  wire logic [ssag_pkg::FUNC_W-1:0] func,
  output logic                             cmd_stall,
  output ssag_pkg::ctrl_cmd_t              cmd,
  input  wire ssag_pkg::ctrl_sts_t         sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVGO = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL1  = 3'd3;
  localparam logic [2:0] S_MUL2  = 3'd4;
  localparam logic [2:0] S_MUL3  = 3'd5;
  localparam logic [2:0] S_STEP  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       op_emit;
  logic       op_emit_next;

  assign cmd_stall = state != S_IDLE;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    op_emit_next = op_emit;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd.accept   = 1'b1;
          op_emit_next = func == ssag_pkg::FUNC_EMIT;
          case (func)
            ssag_pkg::FUNC_SEEK: state_next = S_DIVGO;
            ssag_pkg::FUNC_EMIT: state_next = S_MUL1;
            default:             state_next = S_DONE;
          endcase
        end
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_fin = 1'b1;
        if (op_emit) begin
          state_next = S_STEP;
        end else if (sts.dim_zero) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DIVGO;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (sts.step_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      op_emit <= 1'b0;
    end else begin
      state   <= state_next;
      op_emit <= op_emit_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/strided_slice_address_generator_top.sv
// Top level of the strided slice address generator: controller plus datapath.
// Depends on ssag_pkg, ssag_ctrl, ssag_datapath (and ssag_div below it).
//
//   Channel | Signals                                            | Transfer when
//   --------+----------------------------------------------------+----------------------------
//   cmd     | cmd_valid, cmd_stall, func, dim_slot, extent,      | cmd_valid && !cmd_stall
//           | step_bytes, rewind_bytes, chunk_index              |
//   rsp     | rsp_valid, rsp_stall, kind, src_offset,            | rsp_valid && !rsp_stall
//           | dest_offset, byte_count, wrapped                   |
//   cfg     | cfg_we, cfg_index, cfg_data                        | cfg_we
//
// One item at a time. Load and unused codes: accept, then result load.
// Emit: accept, multiply states MUL1 to MUL3, 1 to rank carry steps, result load.
// Seek: for each active dimension a divider start, the bit-serial divide and the multiply
// states MUL1 to MUL3, plus accept and result load.
// Reset is synchronous; no clearing pass. A new item is taken while the previous
// result is still held under rsp_stall; it then waits in its last state for the slot.
`timescale 1ns / 1ps
`default_nettype none

module strided_slice_address_generator_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ssag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssag_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_stall,
  input  wire logic [ssag_pkg::FUNC_W-1:0]       func,
  input  wire logic [ssag_pkg::SLOT_W-1:0]       dim_slot,
  input  wire logic [ssag_pkg::EXT_W-1:0]        extent,
  input  wire logic signed [ssag_pkg::OFF_W-1:0] step_bytes,
  input  wire logic signed [ssag_pkg::OFF_W-1:0] rewind_bytes,
  input  wire logic [ssag_pkg::IDX_W-1:0]        chunk_index,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic                                   kind,
  output logic [ssag_pkg::OFF_W-1:0]             src_offset,
  output logic [ssag_pkg::OFF_W-1:0]             dest_offset,
  output logic [ssag_pkg::CSZ_W-1:0]             byte_count,
  output logic                                   wrapped
);

  ssag_pkg::ctrl_cmd_t cmd;
  ssag_pkg::ctrl_sts_t sts;

  ssag_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .func      (func),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ssag_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .func          (func),
    .dim_slot      (dim_slot),
    .extent        (extent),
    .step_bytes    (step_bytes),
    .rewind_bytes  (rewind_bytes),
    .chunk_index   (chunk_index),
    .rsp_stall     (rsp_stall),
    .rsp_valid     (rsp_valid),
    .kind          (kind),
    .src_offset    (src_offset),
    .dest_offset   (dest_offset),
    .byte_count    (byte_count),
    .wrapped       (wrapped)
  );

endmodule

`default_nettype wire

FILE: dv/ssag_addr_checker.sv
// Address checker for the strided slice address generator: watches cfg, cmd and rsp,
// predicts every response and compares it field by field. Depends on ssag_pkg.
`timescale 1ns / 1ps

module ssag_addr_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ssag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssag_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              cmd_valid,
  input  wire logic                              cmd_stall,
  input  wire logic [ssag_pkg::FUNC_W-1:0]       func,
  input  wire logic [ssag_pkg::SLOT_W-1:0]       dim_slot,
  input  wire logic [ssag_pkg::EXT_W-1:0]        extent,
  input  wire logic [ssag_pkg::OFF_W-1:0]        step_bytes,
  input  wire logic [ssag_pkg::OFF_W-1:0]        rewind_bytes,
  input  wire logic [ssag_pkg::IDX_W-1:0]        chunk_index,
  input  wire logic                              rsp_valid,
  input  wire logic                              rsp_stall,
  input  wire logic                              kind,
  input  wire logic [ssag_pkg::OFF_W-1:0]        src_offset,
  input  wire logic [ssag_pkg::OFF_W-1:0]        dest_offset,
  input  wire logic [ssag_pkg::CSZ_W-1:0]        byte_count,
  input  wire logic                              wrapped,
  output int                                     fail_count,
  output int                                     pending,
  output int                                     chunks_checked,
  output int                                     wraps_checked
);
  import ssag_pkg::*;

  typedef struct packed {
    logic             kind;
    logic [OFF_W-1:0] src;
    logic [OFF_W-1:0] dst;
    logic [CSZ_W-1:0] bytes;
    logic             wrapped;
  } addr_rsp_t;

  logic [ARANK_W-1:0] rank_reg;
  logic [OFF_W-1:0]   base_reg;
  logic [CSZ_W-1:0]   chunk_size_reg;
  logic [EXT_W-1:0]   extent_tab [MAX_RANK];
  logic [OFF_W-1:0]   stride_tab [MAX_RANK];
  logic [OFF_W-1:0]   rewind_tab [MAX_RANK];
  logic [EXT_W-1:0]   coord [MAX_RANK];
  logic [OFF_W-1:0]   cur_offset;
  logic [IDX_W-1:0]   cur_chunk;
  addr_rsp_t          awaited_rsp [$];
  int                 errs;
  int                 chunks;
  int                 wraps;

  function automatic int used_dims();
    if (rank_reg == '0) return 1;
    if (rank_reg > MAX_RANK) return MAX_RANK;
    return int'(rank_reg);
  endfunction

  // zero extent counts as the full 2^32 range
  function automatic logic [EXT_W:0] dim_span(input int d);
    return (extent_tab[d] == '0) ? {1'b1, {EXT_W{1'b0}}} : {1'b0, extent_tab[d]};
  endfunction

  task automatic step_generator(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] slot,
                                input logic [EXT_W-1:0] ext, input logic [OFF_W-1:0] stp,
                                input logic [OFF_W-1:0] rew, input logic [IDX_W-1:0] idx);
    addr_rsp_t                r;
    logic [IDX_W-1:0]         rest;
    logic [OFF_W-1:0]         off;
    logic [EXT_W:0]           nxt;
    logic [IDX_W+CSZ_W-1:0]   prod;
    logic                     carry_done;
    int                       d;
    r = '0;
    r.kind = KIND_ACK;
    case (f)
      FUNC_LOAD: begin
        if (slot < MAX_RANK) begin
          extent_tab[slot] = ext;
          stride_tab[slot] = stp;
          rewind_tab[slot] = rew;
        end
      end
      FUNC_SEEK: begin
        rest = idx;
        off = base_reg;
        for (d = used_dims() - 1; d >= 0; d--) begin
          coord[d] = EXT_W'(rest % dim_span(d));
          rest = rest / dim_span(d);
          off = off + coord[d] * stride_tab[d];
        end
        cur_offset = off;
        cur_chunk = idx;
      end
      FUNC_EMIT: begin
        prod = cur_chunk * chunk_size_reg;
        r.kind = KIND_CHUNK;
        r.src = cur_offset;
        r.dst = prod[OFF_W-1:0];
        r.bytes = chunk_size_reg;
        r.wrapped = 1'b1;
        carry_done = 1'b0;
        for (d = used_dims() - 1; d >= 0 && !carry_done; d--) begin
          nxt = {1'b0, coord[d]} + 1'b1;
          if (nxt < dim_span(d)) begin
            coord[d] = nxt[EXT_W-1:0];
            cur_offset = cur_offset + stride_tab[d];
            r.wrapped = 1'b0;
            carry_done = 1'b1;
          end else begin
            coord[d] = '0;
            cur_offset = cur_offset - rewind_tab[d];
          end
        end
        cur_chunk = cur_chunk + 1'b1;
      end
      default: ;
    endcase
    awaited_rsp.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    addr_rsp_t want;
    if (rst) begin
      rank_reg = 4'd1;
      base_reg = '0;
      chunk_size_reg = 32'd1;
      for (int d = 0; d < MAX_RANK; d++) begin
        extent_tab[d] = '0;
        stride_tab[d] = '0;
        rewind_tab[d] = '0;
        coord[d] = '0;
      end
      cur_offset = '0;
      cur_chunk = '0;
      awaited_rsp.delete();
      errs = 0;
      chunks = 0;
      wraps = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          $error("response transfer with nothing awaited: kind %0d source 0x%0h",
                 kind, src_offset);
          errs++;
        end else begin
          want = awaited_rsp.pop_front();
          check_field("kind", 64'(want.kind), 64'(kind));
          check_field("src_offset", 64'(want.src), 64'(src_offset));
          check_field("dest_offset", 64'(want.dst), 64'(dest_offset));
          check_field("byte_count", 64'(want.bytes), 64'(byte_count));
          check_field("wrapped", 64'(want.wrapped), 64'(wrapped));
          if (want.kind == KIND_CHUNK) chunks++;
          if (want.wrapped) wraps++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ACTIVE_RANK: rank_reg = cfg_data[ARANK_W-1:0];
          REG_BASE_OFFSET: base_reg = cfg_data[OFF_W-1:0];
          REG_CHUNK_SIZE:  chunk_size_reg = cfg_data[CSZ_W-1:0];
          default: ;
        endcase
      end
      if (cmd_valid && !cmd_stall)
        step_generator(func, dim_slot, extent, step_bytes, rewind_bytes, chunk_index);
    end
    fail_count <= errs;
    pending <= awaited_rsp.size();
    chunks_checked <= chunks;
    wraps_checked <= wraps;
  end

endmodule

FILE: dv/strided_slice_address_generator_top_tb.sv
// Testbench top for the strided slice address generator: drives reset, registers,
// commands and response stalls; ssag_addr_checker does the checking. Depends on ssag_pkg.
`timescale 1ns / 1ps

module strided_slice_address_generator_top_tb;
  import ssag_pkg::*;

  localparam logic [FUNC_W-1:0]    FUNC_NOP  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SEGMENTS      = 8;
  localparam int SEGMENT_ITEMS = 200;
  localparam int TAIL_CYCLES   = 400;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 cmd_valid;
  logic                 cmd_stall;
  logic [FUNC_W-1:0]    func;
  logic [SLOT_W-1:0]    dim_slot;
  logic [EXT_W-1:0]     extent;
  logic [OFF_W-1:0]     step_bytes;
  logic [OFF_W-1:0]     rewind_bytes;
  logic [IDX_W-1:0]     chunk_index;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  logic                 kind;
  logic [OFF_W-1:0]     src_offset;
  logic [OFF_W-1:0]     dest_offset;
  logic [CSZ_W-1:0]     byte_count;
  logic                 wrapped;

  int fail_count;
  int pending;
  int chunks_checked;
  int wraps_checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int sent = 0;
  int settings = 0;

  always #5 clk = ~clk;

  strided_slice_address_generator_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .func(func), .dim_slot(dim_slot),
    .extent(extent), .step_bytes(step_bytes), .rewind_bytes(rewind_bytes),
    .chunk_index(chunk_index),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .kind(kind),
    .src_offset(src_offset), .dest_offset(dest_offset),
    .byte_count(byte_count), .wrapped(wrapped)
  );

  ssag_addr_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .func(func), .dim_slot(dim_slot),
    .extent(extent), .step_bytes(step_bytes), .rewind_bytes(rewind_bytes),
    .chunk_index(chunk_index),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .kind(kind),
    .src_offset(src_offset), .dest_offset(dest_offset),
    .byte_count(byte_count), .wrapped(wrapped),
    .fail_count(fail_count), .pending(pending),
    .chunks_checked(chunks_checked), .wraps_checked(wraps_checked)
  );

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
    $display("strided_slice_address_generator_top_tb: FAIL");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [EXT_W-1:0] pick_extent();
    case ($urandom_range(9))
      0: return '0;
      1: return $urandom;
      2: return '1;
      default: return $urandom_range(1, 5);
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] pick_offset();
    case ($urandom_range(5))
      0: return 48'h8000_0000_0000;
      1: return 48'h7FFF_FFFF_FFFF;
      2, 3: return OFF_W'(rand64());
      default: return OFF_W'(longint'($urandom_range(4096)) - 2048);
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(3))
      0: return IDX_W'(rand64());
      1: return '1;
      default: return IDX_W'($urandom_range(300));
    endcase
  endfunction

  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                          input logic [EXT_W-1:0] e, input logic [OFF_W-1:0] st,
                          input logic [OFF_W-1:0] rw, input logic [IDX_W-1:0] ix);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    func <= f;
    dim_slot <= s;
    extent <= e;
    step_bytes <= st;
    rewind_bytes <= rw;
    chunk_index <= ix;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_emit();
    send_cmd(FUNC_EMIT, SLOT_W'($urandom), $urandom, OFF_W'(rand64()), OFF_W'(rand64()),
             IDX_W'(rand64()));
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // bits above each register's width are don't-care; fill them half the time
  task automatic configure(input logic [ARANK_W-1:0] rank, input logic [OFF_W-1:0] base,
                           input logic [CSZ_W-1:0] csize);
    logic [63:0] junk;
    junk = $urandom_range(1) ? rand64() : 64'd0;
    write_reg(REG_ACTIVE_RANK, {junk[CFG_W-ARANK_W-1:0], rank});
    write_reg(REG_BASE_OFFSET, base);
    write_reg(REG_CHUNK_SIZE, {junk[CFG_W-CSZ_W-1:0], csize});
    write_reg(REG_SPARE, junk[CFG_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    int count;
    int nload;
    int nemit;
    logic [ARANK_W-1:0] rank;
    logic [OFF_W-1:0] base;
    logic [CSZ_W-1:0] csize;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_valid = 1'b0;
    func = FUNC_LOAD;
    dim_slot = '0;
    extent = '0;
    step_bytes = '0;
    rewind_bytes = '0;
    chunk_index = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: fill every slot, extreme fields, full index, wraps, stale coordinates
    configure(4'd8, '1, '1);
    send_cmd(FUNC_LOAD, 3'd0, 32'd2, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, '0);
    send_cmd(FUNC_LOAD, 3'd1, '0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, '1);
    send_cmd(FUNC_LOAD, 3'd2, '1, '1, '1, '0);
    for (int s = 3; s < MAX_RANK - 1; s++)
      send_cmd(FUNC_LOAD, SLOT_W'(s), 32'd1, pick_offset(), pick_offset(), '0);
    send_cmd(FUNC_LOAD, '1, 32'd1, '1, '1, '1);
    send_cmd(FUNC_SEEK, '1, '1, '1, '1, '1);
    send_emit();
    send_emit();
    send_cmd(FUNC_LOAD, 3'd1, 32'd1, 48'd64, 48'd128, '0);
    send_cmd(FUNC_LOAD, 3'd2, 32'd1, 48'd8, 48'd16, '0);
    send_emit();
    send_emit();
    send_emit();
    send_cmd(FUNC_NOP, '1, '1, '1, '1, '1);
    send_cmd(FUNC_SEEK, '0, '0, '0, '0, '0);
    send_emit();
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin rank = 4'd8; base = '0; csize = '1; end
        1: begin rank = 4'd1; base = '1; csize = 32'd1; end
        2: begin rank = 4'd0; base = OFF_W'(rand64()); csize = '0; end
        3: begin rank = 4'd15; base = OFF_W'(rand64()); csize = $urandom; end
        default: begin
          rank = ARANK_W'($urandom_range(15));
          base = OFF_W'(rand64());
          csize = $urandom_range(1) ? $urandom : $urandom_range(1, 64);
        end
      endcase
      configure(rank, base, csize);
      case (seg % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 53; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 53; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      count = 0;
      while (count < SEGMENT_ITEMS) begin
        if ((seg == 0 || seg == 6) && count >= 60 && hold_asked == hold_taken
            && hold_left == 0 && hold_asked < (seg == 0 ? 1 : 2))
          hold_asked++;
        if (seg == 3 && count >= 100 && count < 130) begin
          drain();
          count = 130;
        end
        if ($urandom_range(99) < 85) begin
          nload = $urandom_range(3);
          nemit = $urandom_range(3, 20);
          repeat (nload)
            send_cmd(FUNC_LOAD, SLOT_W'($urandom_range(MAX_RANK - 1)), pick_extent(),
                     pick_offset(), pick_offset(), IDX_W'(rand64()));
          send_cmd(FUNC_SEEK, SLOT_W'($urandom), $urandom, OFF_W'(rand64()),
                   OFF_W'(rand64()), pick_index());
          repeat (nemit) send_emit();
          count += nload + 1 + nemit;
        end else begin
          send_cmd(FUNC_W'($urandom_range(3)), SLOT_W'($urandom), pick_extent(),
                   pick_offset(), OFF_W'(rand64()), pick_index());
          count++;
        end
      end
      drain();
    end

    @(negedge clk);
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d commands over %0d register settings and four flow-control mixes,",
             sent, settings);
    $display("with %0d chunk addresses checked, %0d of them wrapping every dimension",
             chunks_checked, wraps_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("strided_slice_address_generator_top_tb: PASS");
    end else begin
      $display("strided_slice_address_generator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
